// ----- src/vslc_pkg.sv -----
// Package for the velocity slew limiter command unit.
// Holds the config and control-word types, the digit tables and the microprogram.
// No dependencies.
package vslc_pkg;

    localparam int VAL_W  = 16;
    localparam int REG_W  = 15;
    localparam int IDX_W  = 3;
    localparam int PC_W   = 5;

    // config register indexes
    localparam logic [IDX_W-1:0] REG_MAX_ANG  = 3'd0;
    localparam logic [IDX_W-1:0] REG_MAX_LIN  = 3'd1;
    localparam logic [IDX_W-1:0] REG_STEP_ANG = 3'd2;
    localparam logic [IDX_W-1:0] REG_STEP_LIN = 3'd3;

    localparam logic [2:0] POW_TENK = 3'd0;
    localparam logic [2:0] POW_K    = 3'd1;
    localparam logic [2:0] POW_H    = 3'd2;
    localparam logic [2:0] POW_T    = 3'd3;
    localparam logic [2:0] POW_ONES = 3'd4;

    localparam logic SEL_ANG = 1'b0;
    localparam logic SEL_LIN = 1'b1;

    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_M     = 8'h4d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef enum logic [4:0] {
        OP_WAIT  = 5'b00001,  // take the next word from the input channel
        OP_SLEW  = 5'b00010,  // clamp/slew both channels, update saved values
        OP_CHAR  = 5'b00100,  // emit the constant in arg
        OP_SIGN  = 5'b01000,  // load magnitude of selected value, '-' if negative
        OP_DIGIT = 5'b10000   // emit one decimal digit, power index in arg
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] arg;
        logic       sel;
        logic       last;
        logic       eop;
    } ctrl_t;

    typedef struct packed {
        logic [REG_W-1:0] max_ang;
        logic [REG_W-1:0] max_lin;
        logic [REG_W-1:0] step_ang;
        logic [REG_W-1:0] step_lin;
    } cfg_t;

    function automatic logic [16:0] pow10(input logic [2:0] p);
        logic [16:0] r;
        unique case (p)
            POW_TENK: r = 17'd10000;
            POW_K:    r = 17'd1000;
            POW_H:    r = 17'd100;
            POW_T:    r = 17'd10;
            default:  r = 17'd1;
        endcase
        return r;
    endfunction

    function automatic ctrl_t cw(input op_t op, input logic [7:0] arg, input logic sel,
                                 input logic last, input logic eop);
        ctrl_t c;
        c.op   = op;
        c.arg  = arg;
        c.sel  = sel;
        c.last = last;
        c.eop  = eop;
        return c;
    endfunction

    // microprogram: "!M <ang> <lin>\n" then NUL
    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t c;
        unique case (pc)
            5'd0:    c = cw(OP_WAIT,  8'h00,            SEL_ANG, 1'b0, 1'b0);
            5'd1:    c = cw(OP_SLEW,  8'h00,            SEL_ANG, 1'b0, 1'b0);
            5'd2:    c = cw(OP_CHAR,  CH_BANG,          SEL_ANG, 1'b0, 1'b0);
            5'd3:    c = cw(OP_CHAR,  CH_M,             SEL_ANG, 1'b0, 1'b0);
            5'd4:    c = cw(OP_CHAR,  CH_SPACE,         SEL_ANG, 1'b0, 1'b0);
            5'd5:    c = cw(OP_SIGN,  8'h00,            SEL_ANG, 1'b0, 1'b0);
            5'd6:    c = cw(OP_DIGIT, {5'd0, POW_TENK}, SEL_ANG, 1'b0, 1'b0);
            5'd7:    c = cw(OP_DIGIT, {5'd0, POW_K},    SEL_ANG, 1'b0, 1'b0);
            5'd8:    c = cw(OP_DIGIT, {5'd0, POW_H},    SEL_ANG, 1'b0, 1'b0);
            5'd9:    c = cw(OP_DIGIT, {5'd0, POW_T},    SEL_ANG, 1'b0, 1'b0);
            5'd10:   c = cw(OP_DIGIT, {5'd0, POW_ONES}, SEL_ANG, 1'b0, 1'b0);
            5'd11:   c = cw(OP_CHAR,  CH_SPACE,         SEL_ANG, 1'b0, 1'b0);
            5'd12:   c = cw(OP_SIGN,  8'h00,            SEL_LIN, 1'b0, 1'b0);
            5'd13:   c = cw(OP_DIGIT, {5'd0, POW_TENK}, SEL_LIN, 1'b0, 1'b0);
            5'd14:   c = cw(OP_DIGIT, {5'd0, POW_K},    SEL_LIN, 1'b0, 1'b0);
            5'd15:   c = cw(OP_DIGIT, {5'd0, POW_H},    SEL_LIN, 1'b0, 1'b0);
            5'd16:   c = cw(OP_DIGIT, {5'd0, POW_T},    SEL_LIN, 1'b0, 1'b0);
            5'd17:   c = cw(OP_DIGIT, {5'd0, POW_ONES}, SEL_LIN, 1'b0, 1'b0);
            5'd18:   c = cw(OP_CHAR,  CH_NL,            SEL_ANG, 1'b0, 1'b0);
            5'd19:   c = cw(OP_CHAR,  CH_NUL,           SEL_ANG, 1'b1, 1'b1);
            default: c = cw(OP_WAIT,  8'h00,            SEL_ANG, 1'b0, 1'b1);
        endcase
        return c;
    endfunction

endpackage

// ----- src/vslc_seq.sv -----
// Microprogram sequencer: step counter and control-word fetch.
// Depends on vslc_pkg.
module vslc_seq import vslc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  logic  emit,
    input  logic  out_free,
    output ctrl_t ctrl,
    output logic  go,
    output logic  s_ready
);

    logic [PC_W-1:0] pc_reg, pc_next;

    assign ctrl    = ucode(pc_reg);
    assign s_ready = (ctrl.op == OP_WAIT);

    // wait step holds until a word arrives; emitting steps hold while the output is full
    always_comb begin
        if (ctrl.op == OP_WAIT) begin
            go = s_valid;
        end else begin
            go = !emit || out_free;
        end
    end

    always_comb begin
        pc_next = pc_reg;
        if (go) begin
            pc_next = ctrl.eop ? '0 : pc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ----- src/vslc_dp.sv -----
// Datapath: clamp, slew limit, saved values and decimal digit formatting.
// Depends on vslc_pkg.
module vslc_dp import vslc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ctrl_t                   ctrl,
    input  logic                    go,
    input  cfg_t                    cfg,
    input  logic signed [VAL_W-1:0] s_angular_target,
    input  logic signed [VAL_W-1:0] s_linear_target,
    output logic                    emit,
    output logic [7:0]              out_byte,
    output logic                    out_last
);

    function automatic logic signed [VAL_W-1:0] clamp_f(input logic signed [VAL_W-1:0] v,
                                                         input logic [REG_W-1:0] m);
        logic signed [VAL_W:0] vx, mx, nmx;
        logic signed [VAL_W-1:0] r;
        vx  = {v[VAL_W-1], v};
        mx  = {2'b00, m};
        nmx = -mx;
        if (vx > mx) begin
            r = VAL_W'(mx);
        end else if (vx < nmx) begin
            r = VAL_W'(nmx);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic signed [VAL_W-1:0] slew_f(input logic signed [VAL_W-1:0] t,
                                                        input logic signed [VAL_W-1:0] s,
                                                        input logic [REG_W-1:0] st);
        logic signed [VAL_W:0] diff, stx, up, dn;
        logic [VAL_W:0] mag;
        logic signed [VAL_W-1:0] r;
        diff = {t[VAL_W-1], t} - {s[VAL_W-1], s};
        mag  = diff[VAL_W] ? -diff : diff;
        stx  = {2'b00, st};
        up   = {s[VAL_W-1], s} + stx;
        dn   = {s[VAL_W-1], s} - stx;
        if (mag > {2'b00, st}) begin
            r = (t >= s) ? VAL_W'(up) : VAL_W'(dn);
        end else if (t == '0) begin
            r = '0;
        end else begin
            r = s;
        end
        return r;
    endfunction

    logic signed [VAL_W-1:0] tgt_ang_reg, tgt_lin_reg;
    logic signed [VAL_W-1:0] saved_ang_reg, saved_lin_reg;
    logic [REG_W-1:0]        mag_reg, mag_next;
    logic                    started_reg, started_next;
    logic signed [VAL_W-1:0] sel_val;
    logic [2:0]              pidx;
    logic [16:0]             pw;
    logic [3:0]              digit;
    logic [16:0]             sub;
    logic                    is_ones;

    assign sel_val = (ctrl.sel == SEL_LIN) ? saved_lin_reg : saved_ang_reg;
    assign pidx    = ctrl.arg[2:0];
    assign pw      = pow10(pidx);
    assign is_ones = (pidx == POW_ONES);

    // digit = number of multiples of the power that fit; compares are independent
    always_comb begin
        digit = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if ({2'b00, mag_reg} >= 17'(pw * 17'(k))) begin
                digit = 4'(k);
            end
        end
        sub = 17'(pw * {13'd0, digit});
    end

    always_comb begin
        mag_next     = mag_reg;
        started_next = started_reg;
        emit         = 1'b0;
        out_byte     = ctrl.arg;
        out_last     = ctrl.last;
        unique case (ctrl.op)
            OP_WAIT, OP_SLEW: begin
                emit = 1'b0;
            end
            OP_CHAR: begin
                emit = 1'b1;
            end
            OP_SIGN: begin
                emit         = sel_val[VAL_W-1];
                out_byte     = CH_MINUS;
                mag_next     = sel_val[VAL_W-1] ? REG_W'(-sel_val) : REG_W'(sel_val);
                started_next = 1'b0;
            end
            OP_DIGIT: begin
                emit         = (digit != 4'd0) || started_reg || is_ones;
                out_byte     = CH_ZERO | {4'd0, digit};
                mag_next     = REG_W'({2'b00, mag_reg} - sub);
                started_next = started_reg || (digit != 4'd0);
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            saved_ang_reg <= '0;
            saved_lin_reg <= '0;
            started_reg   <= 1'b0;
        end else if (go) begin
            if (ctrl.op == OP_SLEW) begin
                saved_ang_reg <= slew_f(tgt_ang_reg, saved_ang_reg, cfg.step_ang);
                saved_lin_reg <= slew_f(tgt_lin_reg, saved_lin_reg, cfg.step_lin);
            end
            started_reg <= started_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            if (ctrl.op == OP_WAIT) begin
                tgt_ang_reg <= clamp_f(s_angular_target, cfg.max_ang);
                tgt_lin_reg <= clamp_f(s_linear_target, cfg.max_lin);
            end
            mag_reg <= mag_next;
        end
    end

endmodule

// ----- src/velocity_slew_limit_ascii_cmd_unit.sv -----
// Top level of the velocity slew limiter command unit.
// Depends on vslc_pkg, vslc_seq and vslc_dp.
//
// Usage:
//   The input channel (s_valid/s_ready) takes one word holding an angular and a
//   linear velocity target. Each is clamped to +/- its configured maximum, slew
//   limited against the value saved from the previous word, and saved again.
//   The result channel (m_valid/m_ready) then returns the ASCII command
//   "!M <ang> <lin>\n" one byte per word, followed by a NUL byte with
//   m_last_byte high; 8 to 18 bytes per input word.
//   Timing: a microprogram of 20 steps, one step per clock while no step is held:
//   wait, slew, then 18 formatting steps (characters, plus sign and five digit
//   positions per value; suppressed leading zeros still take their step).
//   After accept, the slew step runs before the first byte is registered.
//   s_ready is high only in the wait step.
//   A stall on m_ready holds the sequencer at the next emitting step; the
//   single output register keeps the pending byte.
//   Reset (aresetn low, synchronous) clears saved values to zero, sets the
//   limits to 32767 and the steps to 40 and 80. Config writes (cfg_we) must
//   go in while idle, not enforced by the block; index 0..3, others dropped.
module velocity_slew_limit_ascii_cmd_unit import vslc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [VAL_W-1:0] s_angular_target,
    input  logic signed [VAL_W-1:0] s_linear_target,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [7:0]              m_cmd_byte,
    output logic                    m_last_byte,
    input  logic                    cfg_we,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [REG_W-1:0]        cfg_wdata
);

    cfg_t       cfg_reg;
    ctrl_t      ctrl;
    logic       go, emit, out_free, out_last;
    logic [7:0] out_byte;
    logic       m_valid_reg;
    logic [7:0] m_cmd_byte_reg;
    logic       m_last_byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_ang  <= REG_W'(32767);
            cfg_reg.max_lin  <= REG_W'(32767);
            cfg_reg.step_ang <= REG_W'(40);
            cfg_reg.step_lin <= REG_W'(80);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MAX_ANG:  cfg_reg.max_ang  <= cfg_wdata;
                REG_MAX_LIN:  cfg_reg.max_lin  <= cfg_wdata;
                REG_STEP_ANG: cfg_reg.step_ang <= cfg_wdata;
                REG_STEP_LIN: cfg_reg.step_lin <= cfg_wdata;
                default: ;
            endcase
        end
    end

    vslc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .emit     (emit),
        .out_free (out_free),
        .ctrl     (ctrl),
        .go       (go),
        .s_ready  (s_ready)
    );

    vslc_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (ctrl),
        .go               (go),
        .cfg              (cfg_reg),
        .s_angular_target (s_angular_target),
        .s_linear_target  (s_linear_target),
        .emit             (emit),
        .out_byte         (out_byte),
        .out_last         (out_last)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (go && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (go && emit) begin
            m_cmd_byte_reg  <= out_byte;
            m_last_byte_reg <= out_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_cmd_byte  = m_cmd_byte_reg;
    assign m_last_byte = m_last_byte_reg;

`ifndef SYNTH
    a_one_word_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a command is in progress");

    a_last_is_nul: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_byte) |-> (m_cmd_byte == CH_NUL))
        else $error("last word is not the NUL terminator");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (go && emit) |-> (!m_valid || m_ready))
        else $error("output register overwritten while full");
`endif

endmodule

// ----- tb/sv/velocity_slew_limit_ascii_cmd_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench for velocity_slew_limit_ascii_cmd_unit: streams velocity target words, predicts
// the clamped and slewed "!M <ang> <lin>" command bytes and checks each result word in order.
// Depends on vslc_pkg and the unit's RTL.
module velocity_slew_limit_ascii_cmd_unit_tb;
    import vslc_pkg::*;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int TAIL_CYCLES     = 25;
    localparam int MAG_MAX         = 32767;

    // receiver stall patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_RANDOM = 1;
    localparam int RX_CHOKE  = 2;

    typedef struct packed {
        logic signed [VAL_W-1:0] ang;
        logic signed [VAL_W-1:0] lin;
    } vel_pair_t;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } cmd_byte_t;

    logic                    aclk             = 1'b0;
    logic                    aresetn          = 1'b0;
    logic                    s_valid          = 1'b0;
    logic                    s_ready;
    logic signed [VAL_W-1:0] s_angular_target = '0;
    logic signed [VAL_W-1:0] s_linear_target  = '0;
    logic                    m_valid;
    logic                    m_ready          = 1'b0;
    logic [7:0]              m_cmd_byte;
    logic                    m_last_byte;
    logic                    cfg_we           = 1'b0;
    logic [IDX_W-1:0]        cfg_index        = '0;
    logic [REG_W-1:0]        cfg_wdata        = '0;

    // predictor state: limits as last written, and the slewed values held per axis
    cfg_t      lim_cfg;
    int        held_ang;
    int        held_lin;

    vel_pair_t targets_pending[$];
    cmd_byte_t bytes_due[$];
    vel_pair_t tx_pair;
    cmd_byte_t rx_due;
    int        mismatches   = 0;
    int        burst_left   = 1;
    int        gap_left     = 0;
    int        rx_mode      = RX_OPEN;
    int        rx_win       = 0;
    int        quiet_cycles = 0;

    velocity_slew_limit_ascii_cmd_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_angular_target (s_angular_target),
        .s_linear_target  (s_linear_target),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cmd_byte       (m_cmd_byte),
        .m_last_byte      (m_last_byte),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic int clip_to_limit(int v, int lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // move at most one step toward the target; inside the step the held value stays,
    // except that a zero target snaps it to zero
    function automatic int slew_toward(int target, int held, int stepv);
        int diff;
        int mag;
        diff = target - held;
        mag  = (diff < 0) ? -diff : diff;
        if (mag > stepv)
            return (target >= held) ? held + stepv : held - stepv;
        if (target == 0)
            return 0;
        return held;
    endfunction

    function automatic void push_cmd_byte(logic [7:0] code, logic last);
        cmd_byte_t b;
        b.code = code;
        b.last = last;
        bytes_due.push_back(b);
    endfunction

    function automatic void push_decimal(int v);
        string digits;
        int    mag;
        mag = v;
        if (v < 0) begin
            push_cmd_byte(CH_MINUS, 1'b0);
            mag = -v;
        end
        digits = $sformatf("%0d", mag);
        for (int i = 0; i < digits.len(); i++)
            push_cmd_byte(digits[i], 1'b0);
    endfunction

    function automatic void predict_command(logic signed [VAL_W-1:0] a,
                                            logic signed [VAL_W-1:0] l);
        int ang;
        int lin;
        ang = slew_toward(clip_to_limit($signed(a), int'(lim_cfg.max_ang)), held_ang,
                          int'(lim_cfg.step_ang));
        lin = slew_toward(clip_to_limit($signed(l), int'(lim_cfg.max_lin)), held_lin,
                          int'(lim_cfg.step_lin));
        held_ang = ang;
        held_lin = lin;
        push_cmd_byte(CH_BANG, 1'b0);
        push_cmd_byte(CH_M, 1'b0);
        push_cmd_byte(CH_SPACE, 1'b0);
        push_decimal(ang);
        push_cmd_byte(CH_SPACE, 1'b0);
        push_decimal(lin);
        push_cmd_byte(CH_NL, 1'b0);
        push_cmd_byte(CH_NUL, 1'b1);
    endfunction

    function automatic void queue_pair(int a, int l);
        vel_pair_t p;
        p.ang = a[VAL_W-1:0];
        p.lin = l[VAL_W-1:0];
        targets_pending.push_back(p);
    endfunction

    function automatic int random_target(int lim);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom_range(0, 65535) - 32768;
            3, 4, 5: v = $urandom_range(0, 600) - 300;
            6:       v = 0;
            7: begin
                case ($urandom_range(0, 2))
                    0:       v = MAG_MAX;
                    1:       v = -MAG_MAX;
                    default: v = -MAG_MAX - 1;
                endcase
            end
            default: begin
                // just around the current limit, either sign
                v = lim + $urandom_range(0, 8) - 4;
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic logic [REG_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return REG_W'(MAG_MAX);
            2:       return REG_W'($urandom_range(1, 20));
            3:       return REG_W'($urandom_range(21, 400));
            default: return REG_W'($urandom_range(0, MAG_MAX));
        endcase
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_MAX_ANG:  lim_cfg.max_ang  = val;
            REG_MAX_LIN:  lim_cfg.max_lin  = val;
            REG_STEP_ANG: lim_cfg.step_ang = val;
            REG_STEP_LIN: lim_cfg.step_lin = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // sender holds off until every pending word went in and every byte came back
    task automatic drain_results();
        do
            @(negedge aclk);
        while (targets_pending.size() != 0 || s_valid || bytes_due.size() != 0);
    endtask

    task automatic set_limits(input logic [REG_W-1:0] max_a, input logic [REG_W-1:0] max_l,
                              input logic [REG_W-1:0] step_a, input logic [REG_W-1:0] step_l);
        drain_results();
        write_reg(REG_MAX_ANG, max_a);
        write_reg(REG_MAX_LIN, max_l);
        write_reg(REG_STEP_ANG, step_a);
        write_reg(REG_STEP_LIN, step_l);
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready)
                predict_command(s_angular_target, s_linear_target);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (targets_pending.size() > 0) begin
                    tx_pair = targets_pending.pop_front();
                    s_valid          <= 1'b1;
                    s_angular_target <= tx_pair.ang;
                    s_linear_target  <= tx_pair.lin;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern is redrawn whenever its random window runs out
    always @(posedge aclk) begin
        if (rx_win == 0) begin
            rx_mode = $urandom_range(RX_OPEN, RX_CHOKE);
            rx_win  = $urandom_range(16, 120);
        end else begin
            rx_win--;
        end
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
            default:   m_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (bytes_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word: expected none, actual byte 0x%02h last %0b",
                         $time, m_cmd_byte, m_last_byte);
            end else begin
                rx_due = bytes_due.pop_front();
                if (m_cmd_byte !== rx_due.code) begin
                    mismatches++;
                    $display("%0t: cmd_byte: expected 0x%02h, actual 0x%02h",
                             $time, rx_due.code, m_cmd_byte);
                end
                if (m_last_byte !== rx_due.last) begin
                    mismatches++;
                    $display("%0t: last_byte: expected %0b, actual %0b",
                             $time, rx_due.last, m_last_byte);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: watchdog: no handshake for %0d cycles, %0d bytes outstanding",
                     $time, quiet_cycles, bytes_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        lim_cfg.max_ang  = REG_W'(MAG_MAX);
        lim_cfg.max_lin  = REG_W'(MAG_MAX);
        lim_cfg.step_ang = REG_W'(40);
        lim_cfg.step_lin = REG_W'(80);
        held_ang = 0;
        held_lin = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // limits at reset: slew by 40 and 80 per word
        queue_pair(0, 0);
        queue_pair(100, -100);
        queue_pair(100, -100);
        queue_pair(-MAG_MAX - 1, MAG_MAX);
        queue_pair(-5, 7);

        // wide steps reach five-digit negatives, the longest command
        set_limits(MAG_MAX, MAG_MAX, 30000, 30000);
        queue_pair(-MAG_MAX - 1, -MAG_MAX - 1);
        queue_pair(-MAG_MAX - 1, -MAG_MAX - 1);
        queue_pair(MAG_MAX, MAG_MAX);
        queue_pair(MAG_MAX, MAG_MAX);
        queue_pair(1, -1);
        queue_pair(0, 0);

        set_limits(MAG_MAX, MAG_MAX, 1000, 1000);
        queue_pair(1234, -4321);
        queue_pair(1234, -4321);

        // zero step freezes both axes, zero target included
        set_limits(MAG_MAX, MAG_MAX, 0, 0);
        queue_pair(500, -500);
        queue_pair(0, 0);

        // indexes past the last register must not touch anything
        drain_results();
        for (int k = REG_STEP_LIN + 1; k < 2 ** IDX_W; k++)
            write_reg(IDX_W'(k), REG_W'($urandom()));
        queue_pair(500, -500);

        // limit dropped below the held value: held value survives within one step
        set_limits(600, 600, 500, 500);
        queue_pair(5000, -5000);
        queue_pair(0, 0);
        queue_pair(0, 0);

        set_limits(0, 0, MAG_MAX, MAG_MAX);
        queue_pair(MAG_MAX, -MAG_MAX - 1);
        queue_pair(-1, 1);

        for (int ph = 0; ph < 5; ph++) begin
            if (ph == 0)
                set_limits(MAG_MAX, MAG_MAX, MAG_MAX, MAG_MAX);
            else
                set_limits(pick_limit(), pick_limit(), pick_limit(), pick_limit());
            for (int i = 0; i < 60; i++) begin
                if (ph == 2 && i == 30)
                    drain_results();
                queue_pair(random_target(int'(lim_cfg.max_ang)),
                           random_target(int'(lim_cfg.max_lin)));
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatches == 0 && bytes_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
